>>> hdl/lsba_pkg.sv
`default_nettype none
package lsba_pkg;

    localparam int unsigned MAX_BEAMS   = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned RANGE_W     = 13;
    localparam int unsigned COORD_W     = 15;
    localparam int unsigned TRIG_W      = 15;
    localparam int unsigned ANG_W       = 10;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned SIN_ENTRIES = 181;
    localparam int unsigned QUARTER     = 180;
    localparam int unsigned FULL_TURN   = 720;
    localparam int unsigned PADDR_W     = 5;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned SERIES_LEN  = 8;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // (n - 1) * n for the odd series terms n = 3, 5, ..., 17
    localparam longint unsigned SERIES_DIV [0:SERIES_LEN-1] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [2:0] {
        REG_ANGLE_OFFSET = 3'd0,
        REG_SHIFT_X      = 3'd1,
        REG_SHIFT_Y      = 3'd2,
        REG_BOX_LEFT     = 3'd3,
        REG_BOX_BOTTOM   = 3'd4,
        REG_BOX_WIDTH    = 3'd5,
        REG_BOX_HEIGHT   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [10:0] angle_offset_half_deg;
        logic signed [12:0] shift_x_cm;
        logic signed [12:0] shift_y_cm;
        logic signed [13:0] box_left_cm;
        logic signed [13:0] box_bottom_cm;
        logic [12:0]        box_width_cm;
        logic [12:0]        box_height_cm;
    } cfg_t;

    // one classified sample, handed from the front end to the datapath
    typedef struct packed {
        logic [RANGE_W-1:0] range_cm;
        logic               cos_neg;
        logic [TRIG_W-1:0]  cos_mag;
        logic               sin_neg;
        logic [TRIG_W-1:0]  sin_mag;
        logic [IDX_W-1:0]   beam_index;
        logic               scan_end;
    } work_t;

    typedef logic [TRIG_W-1:0] sin_tab_t [0:SIN_ENTRIES-1];

    // q0.15 sine of 0..90 degrees in half-degree steps, series evaluated at elaboration
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   sum;
        longint            acc;
        bit                neg;
        int unsigned       k;
        int unsigned       j;
        for (k = 0; k < SIN_ENTRIES; k++)
        begin
            x    = (longint'(k) * PI_Q30) / 360;
            x2   = (x * x) >> 30;
            term = x;
            acc  = signed'(x);
            neg  = 1'b1;
            for (j = 0; j < SERIES_LEN; j++)
            begin
                term = ((term * x2) >> 30) / SERIES_DIV[j];
                if (neg)
                    acc = acc - signed'(term);
                else
                    acc = acc + signed'(term);
                neg = !neg;
            end
            if (acc < 0)
                acc = 0;
            sum = (unsigned'(acc) + 64'd16384) >> 15;
            if (sum > 64'd32767)
                sum = 64'd32767;
            tab[k] = sum[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // sign and magnitude of the sine of an angle in 0..719 half degrees
    function automatic logic [TRIG_W:0] sine_lookup(input logic [ANG_W-1:0] ang);
        logic [ANG_W-1:0] r;
        logic [ANG_W-1:0] idx;
        logic             neg;
        if (ang >= ANG_W'(3 * QUARTER))
        begin
            r   = ang - ANG_W'(3 * QUARTER);
            idx = ANG_W'(QUARTER) - r;
            neg = 1'b1;
        end
        else if (ang >= ANG_W'(2 * QUARTER))
        begin
            r   = ang - ANG_W'(2 * QUARTER);
            idx = r;
            neg = 1'b1;
        end
        else if (ang >= ANG_W'(QUARTER))
        begin
            r   = ang - ANG_W'(QUARTER);
            idx = ANG_W'(QUARTER) - r;
            neg = 1'b0;
        end
        else
        begin
            r   = ang;
            idx = r;
            neg = 1'b0;
        end
        return {neg, SIN_TAB[idx[7:0]]};
    endfunction

endpackage
`default_nettype wire

>>> hdl/lsba_if.sv
`default_nettype none
interface lsba_in_if;
    import lsba_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_cm;
    logic               scan_end;

    modport source (output valid, range_cm, scan_end, input ready);
    modport sink (input valid, range_cm, scan_end, output ready);
endinterface

interface lsba_out_if;
    import lsba_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x_cm;
    logic signed [COORD_W-1:0] point_y_cm;
    logic [IDX_W-1:0]          beam_index;
    logic                      inside_box;
    logic                      first_hit;
    logic                      end_of_scan;

    modport source (output valid, point_x_cm, point_y_cm, beam_index, inside_box,
                    first_hit, end_of_scan, input ready);
    modport sink (input valid, point_x_cm, point_y_cm, beam_index, inside_box,
                  first_hit, end_of_scan, output ready);
endinterface
`default_nettype wire

>>> hdl/lsba_front.sv
`default_nettype none
module lsba_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lsba_in_if.sink             samp,
    input  wire lsba_pkg::cfg_t cfg,
    output lsba_pkg::work_t     wr_data,
    output logic                wr_valid,
    input  wire logic           wr_ready
);
    import lsba_pkg::*;

    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [RANGE_W-1:0] s1_range_reg;
    logic               s1_last_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [ANG_W-1:0]   s1_ang_reg;

    logic               s1_ready;
    logic               take;
    logic signed [12:0] diff;
    logic [11:0]        wrapped;
    logic [ANG_W-1:0]   ang;
    logic [ANG_W:0]     cos_sum;
    logic [ANG_W-1:0]   cos_ang;
    logic [TRIG_W:0]    sin_lk;
    logic [TRIG_W:0]    cos_lk;
    logic [IDX_W:0]     cnt_inc;

    assign s1_ready   = !s1_valid_reg || wr_ready;
    assign samp.ready = s1_ready;
    assign take       = samp.valid && s1_ready;

    // beam angle = (index - offset) mod 720
    always_comb
    begin
        diff    = $signed({3'b000, cnt_reg})
                  - $signed({{2{cfg.angle_offset_half_deg[10]}}, cfg.angle_offset_half_deg});
        wrapped = diff[12] ? 12'(diff + 13'sd1440) : diff[11:0];
        if (wrapped >= 12'(2 * FULL_TURN))
            ang = ANG_W'(wrapped - 12'(2 * FULL_TURN));
        else if (wrapped >= 12'(FULL_TURN))
            ang = ANG_W'(wrapped - 12'(FULL_TURN));
        else
            ang = wrapped[ANG_W-1:0];
    end

    always_comb
    begin
        cnt_inc = {1'b0, cnt_reg} + (IDX_W+1)'(1);
        if (samp.scan_end || cnt_inc >= (IDX_W+1)'(MAX_BEAMS))
            cnt_next = '0;
        else
            cnt_next = cnt_inc[IDX_W-1:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (wr_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (take)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_range_reg <= samp.range_cm;
            s1_last_reg  <= samp.scan_end;
            s1_idx_reg   <= cnt_reg;
            s1_ang_reg   <= ang;
        end
    end

    // cosine is the sine a quarter turn ahead
    always_comb
    begin
        cos_sum = {1'b0, s1_ang_reg} + (ANG_W+1)'(QUARTER);
        if (cos_sum >= (ANG_W+1)'(FULL_TURN))
            cos_ang = ANG_W'(cos_sum - (ANG_W+1)'(FULL_TURN));
        else
            cos_ang = cos_sum[ANG_W-1:0];
        sin_lk = sine_lookup(s1_ang_reg);
        cos_lk = sine_lookup(cos_ang);
    end

    assign wr_valid           = s1_valid_reg;
    assign wr_data.range_cm   = s1_range_reg;
    assign wr_data.cos_neg    = cos_lk[TRIG_W];
    assign wr_data.cos_mag    = cos_lk[TRIG_W-1:0];
    assign wr_data.sin_neg    = sin_lk[TRIG_W];
    assign wr_data.sin_mag    = sin_lk[TRIG_W-1:0];
    assign wr_data.beam_index = s1_idx_reg;
    assign wr_data.scan_end   = s1_last_reg;

endmodule
`default_nettype wire

>>> hdl/lsba_queue.sv
`default_nettype none
module lsba_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsba_pkg::work_t wr_data,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    output lsba_pkg::work_t      rd_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready
);
    import lsba_pkg::*;

    work_t             mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign wr_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

>>> hdl/lsba_back.sv
`default_nettype none
module lsba_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsba_pkg::cfg_t  cfg,
    input  wire lsba_pkg::work_t rd_data,
    input  wire logic            rd_valid,
    output logic                 rd_ready,
    lsba_out_if.source           res
);
    import lsba_pkg::*;

    localparam int unsigned PROD_W = RANGE_W + TRIG_W;

    // stage 1: products
    logic               b1_valid_reg;
    logic [PROD_W-1:0]  b1_px_reg;
    logic [PROD_W-1:0]  b1_py_reg;
    logic               b1_xneg_reg;
    logic               b1_yneg_reg;
    logic [IDX_W-1:0]   b1_idx_reg;
    logic               b1_last_reg;
    // stage 2: translated point
    logic                      b2_valid_reg;
    logic signed [COORD_W-1:0] b2_x_reg;
    logic signed [COORD_W-1:0] b2_y_reg;
    logic [IDX_W-1:0]          b2_idx_reg;
    logic                      b2_last_reg;
    // output register
    logic                      o_valid_reg;
    logic signed [COORD_W-1:0] o_x_reg;
    logic signed [COORD_W-1:0] o_y_reg;
    logic [IDX_W-1:0]          o_idx_reg;
    logic                      o_inside_reg;
    logic                      o_first_reg;
    logic                      o_last_reg;
    logic                      hit_reg;
    logic                      hit_next;

    logic b1_ready;
    logic b2_ready;
    logic o_ready;
    logic ld1;
    logic ld2;
    logic ld3;

    logic [PROD_W:0]           rx_sum;
    logic [PROD_W:0]           ry_sum;
    logic [RANGE_W-1:0]        rx;
    logic [RANGE_W-1:0]        ry;
    logic signed [RANGE_W:0]   sx;
    logic signed [RANGE_W:0]   sy;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;

    logic signed [COORD_W:0] xe;
    logic signed [COORD_W:0] ye;
    logic signed [COORD_W:0] left_e;
    logic signed [COORD_W:0] bottom_e;
    logic signed [COORD_W:0] right_e;
    logic signed [COORD_W:0] top_e;
    logic                    in_box;

    assign o_ready  = !o_valid_reg || res.ready;
    assign b2_ready = !b2_valid_reg || o_ready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign rd_ready = b1_ready;
    assign ld1      = rd_valid && b1_ready;
    assign ld2      = b1_valid_reg && b2_ready;
    assign ld3      = b2_valid_reg && o_ready;

    // round half away from zero on the magnitude, then apply sign and shift
    always_comb
    begin
        rx_sum = {1'b0, b1_px_reg} + (PROD_W+1)'(16384);
        ry_sum = {1'b0, b1_py_reg} + (PROD_W+1)'(16384);
        rx     = rx_sum[RANGE_W+TRIG_W-1:TRIG_W];
        ry     = ry_sum[RANGE_W+TRIG_W-1:TRIG_W];
        sx     = b1_xneg_reg ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
        sy     = b1_yneg_reg ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
        x_next = $signed({sx[RANGE_W], sx})
                 + $signed({{2{cfg.shift_x_cm[12]}}, cfg.shift_x_cm});
        y_next = $signed({sy[RANGE_W], sy})
                 + $signed({{2{cfg.shift_y_cm[12]}}, cfg.shift_y_cm});
    end

    // half-open box test
    always_comb
    begin
        xe       = $signed({b2_x_reg[COORD_W-1], b2_x_reg});
        ye       = $signed({b2_y_reg[COORD_W-1], b2_y_reg});
        left_e   = $signed({{2{cfg.box_left_cm[13]}}, cfg.box_left_cm});
        bottom_e = $signed({{2{cfg.box_bottom_cm[13]}}, cfg.box_bottom_cm});
        right_e  = left_e + $signed({3'b000, cfg.box_width_cm});
        top_e    = bottom_e + $signed({3'b000, cfg.box_height_cm});
        in_box   = (xe >= left_e) && (xe < right_e) && (ye >= bottom_e) && (ye < top_e);
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ld3)
        begin
            if (b2_last_reg)
                hit_next = 1'b0;
            else if (in_box)
                hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (b1_ready)
                b1_valid_reg <= rd_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (o_ready)
                o_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            b1_px_reg   <= rd_data.range_cm * rd_data.cos_mag;
            b1_py_reg   <= rd_data.range_cm * rd_data.sin_mag;
            b1_xneg_reg <= rd_data.cos_neg;
            b1_yneg_reg <= rd_data.sin_neg;
            b1_idx_reg  <= rd_data.beam_index;
            b1_last_reg <= rd_data.scan_end;
        end
        if (ld2)
        begin
            b2_x_reg    <= x_next;
            b2_y_reg    <= y_next;
            b2_idx_reg  <= b1_idx_reg;
            b2_last_reg <= b1_last_reg;
        end
        if (ld3)
        begin
            o_x_reg      <= b2_x_reg;
            o_y_reg      <= b2_y_reg;
            o_idx_reg    <= b2_idx_reg;
            o_inside_reg <= in_box;
            o_first_reg  <= in_box && !hit_reg;
            o_last_reg   <= b2_last_reg;
        end
    end

    assign res.valid       = o_valid_reg;
    assign res.point_x_cm  = o_x_reg;
    assign res.point_y_cm  = o_y_reg;
    assign res.beam_index  = o_idx_reg;
    assign res.inside_box  = o_inside_reg;
    assign res.first_hit   = o_first_reg;
    assign res.end_of_scan = o_last_reg;

endmodule
`default_nettype wire

>>> hdl/lidar_scan_box_alert_unit.sv
// path: an accepted sample passes the front-end stage register, the queue, the product register,
// the translated-point register and the output register; throughput: one sample per cycle while the output is not
// stalled, with a combinational table lookup and multipliers; a 4-entry queue between the angle front end and the
// datapath absorbs output stalls; reset: asynchronous active low; clears the beam counter, hit flag, queue and all
// valid flags, and loads the box and offset registers with their default values
`default_nettype none
module lidar_scan_box_alert_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lsba_in_if.sink                              samp,
    lsba_out_if.source                           res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lsba_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [lsba_pkg::PDATA_W-1:0]    pwdata,
    output logic [lsba_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import lsba_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    work_t    wr_data;
    logic     wr_valid;
    logic     wr_ready;
    work_t    rd_data;
    logic     rd_valid;
    logic     rd_ready;
    logic     wr_en;
    reg_idx_t sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_ANGLE_OFFSET: cfg_next.angle_offset_half_deg = pwdata[10:0];
                REG_SHIFT_X:      cfg_next.shift_x_cm            = pwdata[12:0];
                REG_SHIFT_Y:      cfg_next.shift_y_cm            = pwdata[12:0];
                REG_BOX_LEFT:     cfg_next.box_left_cm           = pwdata[13:0];
                REG_BOX_BOTTOM:   cfg_next.box_bottom_cm         = pwdata[13:0];
                REG_BOX_WIDTH:    cfg_next.box_width_cm          = pwdata[12:0];
                REG_BOX_HEIGHT:   cfg_next.box_height_cm         = pwdata[12:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_ANGLE_OFFSET:
                prdata = {{21{cfg_reg.angle_offset_half_deg[10]}}, cfg_reg.angle_offset_half_deg};
            REG_SHIFT_X:
                prdata = {{19{cfg_reg.shift_x_cm[12]}}, cfg_reg.shift_x_cm};
            REG_SHIFT_Y:
                prdata = {{19{cfg_reg.shift_y_cm[12]}}, cfg_reg.shift_y_cm};
            REG_BOX_LEFT:
                prdata = {{18{cfg_reg.box_left_cm[13]}}, cfg_reg.box_left_cm};
            REG_BOX_BOTTOM:
                prdata = {{18{cfg_reg.box_bottom_cm[13]}}, cfg_reg.box_bottom_cm};
            REG_BOX_WIDTH:
                prdata = {19'd0, cfg_reg.box_width_cm};
            REG_BOX_HEIGHT:
                prdata = {19'd0, cfg_reg.box_height_cm};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_offset_half_deg <= 11'sd0;
            cfg_reg.shift_x_cm            <= 13'sd0;
            cfg_reg.shift_y_cm            <= 13'sd0;
            cfg_reg.box_left_cm           <= -14'sd50;
            cfg_reg.box_bottom_cm         <= 14'sd0;
            cfg_reg.box_width_cm          <= 13'd50;
            cfg_reg.box_height_cm         <= 13'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsba_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samp     (samp),
        .cfg      (cfg_reg),
        .wr_data  (wr_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready)
    );

    lsba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (wr_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready)
    );

    lsba_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .res      (res)
    );

endmodule
`default_nettype wire
